[src/ucb_pkg.sv]
// ucb_pkg: shared constants for the UCT best-child selector.
// No dependencies; used by uct_best_child_select and ucb_score.
package ucb_pkg;

	localparam int POS_W         = 4;   // candidate position width
	localparam int KEY_W         = 33;  // ordering key: 0 lowest, else score + 1
	localparam int LOG_FRAC_BITS = 24;
	localparam int LOG_W         = 29;  // Q5.24 log2
	localparam int RATIO_W       = 37;  // ln(Q5.24) << 8
	localparam int SQRT_W        = 38;  // root/bit accumulator of the square root
	localparam int MUL_W         = 32;

	localparam logic [31:0] LN2_Q32  = 32'hB17217F8;
	localparam logic [31:0] Q16_MAX  = 32'hFFFFFFFF;
	localparam logic [7:0]  EXPL_NUM = 8'd144;
	localparam logic [7:0]  EXPL_DEN = 8'd100;

	// ceil(1.44 * 2^30): floor(root * 144 / 100) == (root * EXPL_MUL) >> 30 for root < 2^26
	localparam logic [31:0] EXPL_MUL   = 32'd1546188227;
	localparam int          EXPL_SHIFT = 30;

endpackage

[src/uct_best_child_select.sv]
// UCT best-child selector: scores each candidate of a run, emits best position on last.
// Scored items go through two divides, a log and a square root; divider width
// DW = max(COUNT_BITS+16, 37).
// Items with zero visits or zero parent skip the divides; items past a full run are not scored.
// One item at a time; a held result stalls only the next last item of a run.
// arst_n clears run state, best tracking and output valid.
module uct_best_child_select #(
	parameter int MAX_CHILDREN = 9,
	parameter int COUNT_BITS   = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [COUNT_BITS-1:0]       own_wins,
	input  logic [COUNT_BITS-1:0]       own_visits,
	input  logic [COUNT_BITS-1:0]       above_visits,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ucb_pkg::POS_W-1:0]   best_position
);

	localparam logic [ucb_pkg::POS_W-1:0] MAX_POS = ucb_pkg::POS_W'(MAX_CHILDREN);

	localparam logic [1:0] T_IDLE  = 2'd0;
	localparam logic [1:0] T_SCORE = 2'd1;
	localparam logic [1:0] T_FIN   = 2'd2;

	logic [1:0]                  state_q;
	logic [COUNT_BITS-1:0]       wins_q, visits_q, parent_q;
	logic                        last_q;
	logic                        start_q;
	logic                        sc_done;
	logic [ucb_pkg::KEY_W-1:0]   sc_key;
	logic [ucb_pkg::KEY_W-1:0]   best_score_q;
	logic [ucb_pkg::POS_W-1:0]   best_slot_q;
	logic [ucb_pkg::POS_W-1:0]   run_pos_q;
	logic                        run_full_q;
	logic                        out_valid_q;
	logic [ucb_pkg::POS_W-1:0]   out_pos_q;
	logic                        post;

	ucb_score #(.COUNT_BITS(COUNT_BITS)) u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.wins   (wins_q),
		.visits (visits_q),
		.parent (parent_q),
		.done   (sc_done),
		.key    (sc_key)
	);

	assign in_ready = (state_q == T_IDLE);

	// result transfer slot is free: post result, clear run
	assign post = (state_q == T_FIN) && last_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			wins_q   <= own_wins;
			visits_q <= own_visits;
			parent_q <= above_visits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_pos_q   <= '0;
		end else if (post) begin
			out_valid_q <= 1'b1;
			out_pos_q   <= best_slot_q;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			last_q       <= 1'b0;
			start_q      <= 1'b0;
			best_score_q <= '0;
			best_slot_q  <= '0;
			run_pos_q    <= '0;
			run_full_q   <= 1'b0;
		end else begin
			start_q <= (state_q == T_IDLE) && in_valid && !run_full_q;
			unique case (state_q)
				T_IDLE: begin
					if (in_valid) begin
						last_q <= last;
						if (run_full_q) begin
							state_q <= T_FIN;
						end else begin
							state_q <= T_SCORE;
						end
					end
				end
				T_SCORE: begin
					if (sc_done) begin
						if (run_pos_q == '0 || sc_key > best_score_q) begin
							best_score_q <= sc_key;
							best_slot_q  <= run_pos_q;
						end
						if (run_pos_q >= MAX_POS) run_full_q <= 1'b1;
						else run_pos_q <= run_pos_q + 1'b1;
						state_q <= T_FIN;
					end
				end
				T_FIN: begin
					if (!last_q) begin
						state_q <= T_IDLE;
					end else if (post) begin
						best_score_q <= '0;
						best_slot_q  <= '0;
						run_pos_q    <= '0;
						run_full_q   <= 1'b0;
						state_q      <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign best_position = out_pos_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		best_slot_q <= MAX_POS)
		else $error("best slot beyond last child");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_pos_q <= MAX_POS)
		else $error("run position beyond last child");

	a_done_in_score: assert property (@(posedge clk) disable iff (!arst_n)
		sc_done |-> state_q == T_SCORE)
		else $error("score finished outside scoring");

	a_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> !start_q)
		else $error("score start held");

endmodule

[src/ucb_div.sv]
// ucb_div: restoring divider, one quotient bit per cycle.
// Does not use ucb_pkg; no package items needed here.
module ucb_div #(
	parameter int DW  = 48,
	parameter int DVW = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  dividend,
	input  logic [DVW-1:0] divisor,
	output logic           done,
	output logic [DW-1:0]  quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DVW-1:0] rem_q;
	logic [DW-1:0]  quo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DVW:0]   trial;
	logic           fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVW'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[DVW-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/ucb_score.sv]
// ucb_score: sequencer computing the UCB1 ordering key of one candidate.
// Depends on ucb_pkg and ucb_div; shares one multiplier and one divider.
module ucb_score #(
	parameter int COUNT_BITS = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [COUNT_BITS-1:0]   wins,
	input  logic [COUNT_BITS-1:0]   visits,
	input  logic [COUNT_BITS-1:0]   parent,
	output logic                    done,
	output logic [ucb_pkg::KEY_W-1:0] key
);

	localparam int CB = COUNT_BITS;
	localparam int DW = (CB + 16 > ucb_pkg::RATIO_W) ? CB + 16 : ucb_pkg::RATIO_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIVX  = 4'd1;
	localparam logic [3:0] S_NORM  = 4'd2;
	localparam logic [3:0] S_LOG   = 4'd3;
	localparam logic [3:0] S_LNMUL = 4'd4;
	localparam logic [3:0] S_DIVR  = 4'd5;
	localparam logic [3:0] S_SQRT  = 4'd6;
	localparam logic [3:0] S_MULE  = 4'd7;
	localparam logic [3:0] S_SUM   = 4'd8;

	localparam logic [ucb_pkg::KEY_W-1:0] KEY_W_ONE = 1;

	logic [3:0]    state_q;
	logic          div_go_q;
	logic [DW-1:0] dvd_q;
	logic [CB-1:0] dvs_q;
	logic          div_done;
	logic [DW-1:0] div_quo;

	logic [DW-1:0] exploit_q;
	logic [DW-1:0] explore_q;
	logic [31:0]   x_q;
	logic [4:0]    shift_q;
	logic [ucb_pkg::LOG_FRAC_BITS-1:0] frac_q;
	logic [4:0]    cnt_q;
	logic [ucb_pkg::RATIO_W-1:0] v_q;
	logic [ucb_pkg::SQRT_W-1:0]  root_q;
	logic [ucb_pkg::RATIO_W-1:0] bit_q;
	logic [ucb_pkg::KEY_W-1:0]   key_q;
	logic          done_q;

	logic [ucb_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic [2*ucb_pkg::MUL_W-1:0] prod;
	logic [32:0]   sq;
	logic [ucb_pkg::SQRT_W-1:0]  rb;
	logic          rfit;
	logic [DW:0]   sum;
	logic          div_go;
	logic          fin_now;

	ucb_div #(.DW(DW), .DVW(CB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (dvd_q),
		.divisor  (dvs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// single shared multiplier
	always_comb begin
		unique case (state_q)
			S_LOG: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			S_LNMUL: begin
				mul_a = {3'b000, ~shift_q, frac_q};
				mul_b = ucb_pkg::LN2_Q32;
			end
			S_MULE: begin
				// scale by 1.44 through a fixed-point constant (1.44 * 2^30)
				mul_a = root_q[31:0];
				mul_b = ucb_pkg::EXPL_MUL;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;
	assign sq   = prod[63:31];

	assign rb   = root_q + {1'b0, bit_q};
	assign rfit = {1'b0, v_q} >= rb;
	assign sum  = {1'b0, exploit_q} + {1'b0, explore_q};

	assign div_go  = (state_q == S_IDLE && start && visits != '0 && parent != '0) ||
			state_q == S_LNMUL;
	assign fin_now = (state_q == S_IDLE && start && (visits == '0 || parent == '0)) ||
			state_q == S_SUM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			div_go_q <= div_go;
			done_q   <= fin_now;
			unique case (state_q)
				S_IDLE: begin
					if (start && visits != '0 && parent != '0) state_q <= S_DIVX;
				end
				S_DIVX:  if (div_done) state_q <= S_NORM;
				S_NORM:  if (x_q[31]) state_q <= S_LOG;
				S_LOG:   if (cnt_q == '0) state_q <= S_LNMUL;
				S_LNMUL: state_q <= S_DIVR;
				S_DIVR:  if (div_done) state_q <= S_SQRT;
				S_SQRT:  if (bit_q[0]) state_q <= S_MULE;
				S_MULE:  state_q <= S_SUM;
				S_SUM:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (visits == '0) key_q <= KEY_W_ONE;
				else key_q <= '0;
				dvd_q <= DW'({wins, 16'h0000});
				dvs_q <= visits;
			end
			S_DIVX: begin
				exploit_q <= div_quo;
				x_q       <= 32'(parent);
				shift_q   <= '0;
			end
			S_NORM: begin
				if (!x_q[31]) begin
					x_q     <= {x_q[30:0], 1'b0};
					shift_q <= shift_q + 1'b1;
				end
				cnt_q <= 5'(ucb_pkg::LOG_FRAC_BITS - 1);
			end
			S_LOG: begin
				// square the mantissa; a carry past 2.0 gives one log bit
				if (sq[32]) x_q <= sq[32:1];
				else x_q <= sq[31:0];
				frac_q <= {frac_q[ucb_pkg::LOG_FRAC_BITS-2:0], sq[32]};
				cnt_q  <= cnt_q - 1'b1;
			end
			S_LNMUL: begin
				dvd_q <= DW'({prod[60:32], 8'h00});
			end
			S_DIVR: begin
				v_q    <= div_quo[ucb_pkg::RATIO_W-1:0];
				root_q <= '0;
				bit_q  <= {1'b1, {(ucb_pkg::RATIO_W-1){1'b0}}};
			end
			S_SQRT: begin
				if (rfit) begin
					v_q    <= ucb_pkg::RATIO_W'({1'b0, v_q} - rb);
					root_q <= (root_q >> 1) + {1'b0, bit_q};
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_MULE: begin
				explore_q <= DW'(prod[63:ucb_pkg::EXPL_SHIFT]);
			end
			S_SUM: begin
				if (sum > (DW+1)'(ucb_pkg::Q16_MAX))
					key_q <= {1'b0, ucb_pkg::Q16_MAX} + 1'b1;
				else
					key_q <= ucb_pkg::KEY_W'(sum) + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign key  = key_q;

endmodule
